@@ rtl/cist_pkg.sv @@
// Package for the CAN identifier statistics table.
// Shared types, command/status codes and sizes. No dependencies.
package cist_pkg;

    localparam int TABLE_DEPTH      = 128;
    localparam int LOG_SIZE         = 256;
    localparam int TIDX_W           = $clog2(TABLE_DEPTH);
    localparam int LIDX_W           = $clog2(LOG_SIZE);
    localparam int TFILL_W          = $clog2(TABLE_DEPTH + 1);
    localparam int LFILL_W          = $clog2(LOG_SIZE + 1);

    localparam logic [2:0] CMD_FRAME     = 3'd0;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd1;
    localparam logic [2:0] CMD_CLEAR_LOG = 3'd2;
    localparam logic [2:0] CMD_READ_TAB  = 3'd3;
    localparam logic [2:0] CMD_READ_LOG  = 3'd4;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_EXIST   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_REMOTE  = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;
    localparam logic [2:0] ST_TREAD   = 3'd5;
    localparam logic [2:0] ST_LREAD   = 3'd6;
    localparam logic [2:0] ST_BAD     = 3'd7;

    localparam logic CFG_WATCH_ENABLE = 1'b0;
    localparam logic CFG_WATCH_ID     = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [28:0] frame_id;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic        remote_frame;
        logic [31:0] time_ms;
        logic [7:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [28:0] entry_id;
        logic [3:0]  entry_length;
        logic [31:0] entry_count;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [63:0] last_payload;
        logic [7:0]  chg_mask;
        logic [63:0] low_bytes;
        logic [63:0] high_bytes;
        logic [31:0] total_frames;
        logic [8:0]  fill_count;
    } out_item_t;

    typedef struct packed {
        logic [28:0] entry_id;
        logic [3:0]  entry_length;
        logic [31:0] entry_count;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [63:0] last_payload;
        logic [7:0]  chg_mask;
        logic [63:0] low_bytes;
        logic [63:0] high_bytes;
    } entry_t;

    typedef struct packed {
        logic [31:0] log_time;
        logic [3:0]  log_length;
        logic [63:0] log_payload;
    } log_rec_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;        // capture input item
        logic              tab_rd;      // read table at tab_addr
        logic [TIDX_W-1:0] tab_addr;
        logic              upd;         // compute updated entry from read data
        logic              tab_wr;      // write updated entry back
        logic              new_ent;     // treat read data as fresh entry
        logic              log_rd;      // read log at computed position
        logic              log_wr;      // append log record
        logic              res_load;    // build result
        logic [2:0]        res_status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic id_match;
        logic differs;
    } sts_t;

    function automatic logic [63:0] len_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) m[8*i +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

@@ rtl/cist_datapath.sv @@
// Datapath: entry and log memories, frame update arithmetic, result register.
// Depends on cist_pkg; driven by cist_ctrl.
module cist_datapath
(
    input  logic                clk,
    input  cist_pkg::cmd_t      cmd,
    output cist_pkg::sts_t      sts,
    input  cist_pkg::in_item_t  in_item,
    input  logic [28:0]         watch_id,
    input  logic [31:0]         frame_total,
    input  logic [cist_pkg::TFILL_W-1:0] table_fill,
    input  logic [cist_pkg::LIDX_W-1:0]  log_pos,
    input  logic [cist_pkg::LFILL_W-1:0] log_fill,
    output cist_pkg::out_item_t res
);

    cist_pkg::entry_t   tab_mem [cist_pkg::TABLE_DEPTH];
    cist_pkg::log_rec_t log_mem [cist_pkg::LOG_SIZE];

    cist_pkg::in_item_t item_reg;
    cist_pkg::entry_t   rd_reg;
    cist_pkg::entry_t   upd_reg;
    cist_pkg::log_rec_t lrd_reg;
    cist_pkg::out_item_t res_reg;
    cist_pkg::out_item_t res_next;
    logic               differs_reg;

    logic [3:0]  len_clamp;
    logic [63:0] lmask;
    cist_pkg::entry_t cur;
    cist_pkg::entry_t upd_next;
    logic        differs_next;
    logic [cist_pkg::LIDX_W-1:0] log_rd_addr;

    assign len_clamp = (item_reg.length_code > 4'd8) ? 4'd8 : item_reg.length_code;
    assign lmask     = cist_pkg::len_mask(len_clamp);
    assign log_rd_addr = log_pos - log_fill[cist_pkg::LIDX_W-1:0] + item_reg.read_index;

    always_ff @(posedge clk)
    begin
        if (cmd.load) item_reg <= in_item;
        if (cmd.tab_rd) rd_reg <= tab_mem[cmd.tab_addr];
        if (cmd.tab_wr) tab_mem[cmd.tab_addr] <= upd_reg;
        if (cmd.log_rd) lrd_reg <= log_mem[log_rd_addr];
        if (cmd.log_wr) log_mem[log_pos] <= '{item_reg.time_ms, len_clamp,
                                               item_reg.payload & lmask};
        if (cmd.upd)
        begin
            upd_reg     <= upd_next;
            differs_reg <= differs_next;
        end
    end

    always_comb
    begin
        cur = rd_reg;
        if (cmd.new_ent)
        begin
            cur              = '0;
            cur.entry_id     = item_reg.frame_id;
            cur.first_time   = item_reg.time_ms;
            cur.low_bytes    = '1;
        end
        upd_next = cur;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < len_clamp)
            begin
                if (cur.entry_count != 0 &&
                    item_reg.payload[8*i +: 8] != cur.last_payload[8*i +: 8])
                    upd_next.chg_mask[i] = 1'b1;
                if (item_reg.payload[8*i +: 8] < cur.low_bytes[8*i +: 8])
                    upd_next.low_bytes[8*i +: 8] = item_reg.payload[8*i +: 8];
                if (item_reg.payload[8*i +: 8] > cur.high_bytes[8*i +: 8])
                    upd_next.high_bytes[8*i +: 8] = item_reg.payload[8*i +: 8];
            end
        end
        differs_next = cur.entry_count == 0 || len_clamp != cur.entry_length ||
                       ((cur.last_payload ^ item_reg.payload) & lmask) != 0;
        upd_next.entry_length = len_clamp;
        upd_next.last_payload = (cur.last_payload & ~lmask) | (item_reg.payload & lmask);
        if (cur.entry_count != 32'hFFFF_FFFF)
            upd_next.entry_count = cur.entry_count + 32'd1;
        upd_next.last_time = item_reg.time_ms;
    end

    assign sts.id_match = (rd_reg.entry_id == item_reg.frame_id);
    assign sts.differs  = differs_reg;

    always_comb
    begin
        res_next              = '0;
        res_next.status       = cmd.res_status;
        res_next.total_frames = frame_total;
        res_next.fill_count   = 9'(table_fill);
        case (cmd.res_status)
            cist_pkg::ST_NEW, cist_pkg::ST_EXIST:
            begin
                res_next.entry_id     = upd_reg.entry_id;
                res_next.entry_length = upd_reg.entry_length;
                res_next.entry_count  = upd_reg.entry_count;
                res_next.first_time   = upd_reg.first_time;
                res_next.last_time    = upd_reg.last_time;
                res_next.last_payload = upd_reg.last_payload;
                res_next.chg_mask     = upd_reg.chg_mask;
                res_next.low_bytes    = upd_reg.low_bytes;
                res_next.high_bytes   = upd_reg.high_bytes;
            end
            cist_pkg::ST_TREAD:
            begin
                res_next.entry_id     = rd_reg.entry_id;
                res_next.entry_length = rd_reg.entry_length;
                res_next.entry_count  = rd_reg.entry_count;
                res_next.first_time   = rd_reg.first_time;
                res_next.last_time    = rd_reg.last_time;
                res_next.last_payload = rd_reg.last_payload;
                res_next.chg_mask     = rd_reg.chg_mask;
                res_next.low_bytes    = rd_reg.low_bytes;
                res_next.high_bytes   = rd_reg.high_bytes;
            end
            cist_pkg::ST_LREAD:
            begin
                res_next.entry_id     = watch_id;
                res_next.entry_length = lrd_reg.log_length;
                res_next.last_time    = lrd_reg.log_time;
                res_next.last_payload = lrd_reg.log_payload;
                res_next.fill_count   = 9'(log_fill);
            end
            cist_pkg::ST_FULL, cist_pkg::ST_REMOTE:
                res_next.entry_id     = item_reg.frame_id;
            cist_pkg::ST_BAD:
                if (item_reg.cmd == cist_pkg::CMD_READ_LOG)
                    res_next.fill_count = 9'(log_fill);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load) res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

@@ rtl/cist_ctrl.sv @@
// Controller: sequences search, update, log append and result handoff.
// Holds table/log fill counters and the frame total. Depends on cist_pkg.
module cist_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cist_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                watch_enable,
    input  logic [28:0]         watch_id,
    output cist_pkg::cmd_t      cmd,
    input  cist_pkg::sts_t      sts,
    output logic [31:0]         frame_total,
    output logic [cist_pkg::TFILL_W-1:0] table_fill,
    output logic [cist_pkg::LIDX_W-1:0]  log_pos,
    output logic [cist_pkg::LFILL_W-1:0] log_fill
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [cist_pkg::TFILL_W-1:0] addr_reg, addr_next;
    logic        found_reg, found_next;
    logic [2:0]  status_reg, status_next;
    logic        busy_out_reg, busy_out_next;
    logic [31:0] total_reg, total_next;
    logic [cist_pkg::TFILL_W-1:0] fill_reg, fill_next;
    logic [cist_pkg::LIDX_W-1:0]  lpos_reg, lpos_next;
    logic [cist_pkg::LFILL_W-1:0] lfill_reg, lfill_next;
    logic [28:0] id_reg;
    logic        accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = busy_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept) id_reg <= in_item.frame_id;
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        found_next  = found_reg;
        status_next = status_reg;
        busy_out_next = busy_out_reg && out_stall;
        total_next  = total_reg;
        fill_next   = fill_reg;
        lpos_next   = lpos_reg;
        lfill_next  = lfill_reg;
        cmd         = '0;
        cmd.tab_addr   = addr_reg[cist_pkg::TIDX_W-1:0];
        cmd.res_status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    addr_next  = '0;
                    found_next = 1'b0;
                    state_next = S_RESULT;
                    case (in_item.cmd)
                        cist_pkg::CMD_FRAME:
                            if (in_item.remote_frame)
                                status_next = cist_pkg::ST_REMOTE;
                            else
                            begin
                                if (total_reg != 32'hFFFF_FFFF)
                                    total_next = total_reg + 32'd1;
                                state_next = S_SEARCH;
                            end
                        cist_pkg::CMD_CLEAR_ALL:
                        begin
                            fill_next = '0; total_next = '0;
                            lpos_next = '0; lfill_next = '0;
                            status_next = cist_pkg::ST_CLEARED;
                        end
                        cist_pkg::CMD_CLEAR_LOG:
                        begin
                            lpos_next = '0; lfill_next = '0;
                            status_next = cist_pkg::ST_CLEARED;
                        end
                        cist_pkg::CMD_READ_TAB:
                            if (cist_pkg::TFILL_W'(in_item.read_index) < fill_reg &&
                                {1'b0, in_item.read_index} < 9'(cist_pkg::TABLE_DEPTH))
                            begin
                                addr_next   = cist_pkg::TFILL_W'(in_item.read_index);
                                status_next = cist_pkg::ST_TREAD;
                                state_next  = S_READ;
                            end
                            else
                                status_next = cist_pkg::ST_BAD;
                        cist_pkg::CMD_READ_LOG:
                            if (cist_pkg::LFILL_W'(in_item.read_index) < lfill_reg)
                            begin
                                status_next = cist_pkg::ST_LREAD;
                                state_next  = S_READ;
                            end
                            else
                                status_next = cist_pkg::ST_BAD;
                        default:
                            status_next = cist_pkg::ST_BAD;
                    endcase
                end
            end
            S_SEARCH:
            begin
                // one table entry read per pass
                if (addr_reg < fill_reg)
                begin
                    cmd.tab_rd = 1'b1;
                    state_next = S_CHECK;
                end
                else if (fill_reg == cist_pkg::TFILL_W'(cist_pkg::TABLE_DEPTH))
                begin
                    status_next = cist_pkg::ST_FULL;
                    state_next  = S_RESULT;
                end
                else
                begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = S_UPD;
                end
            end
            S_CHECK:
                if (sts.id_match)
                begin
                    found_next = 1'b1;
                    state_next = S_UPD;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_SEARCH;
                end
            S_UPD:
            begin
                cmd.upd     = 1'b1;
                cmd.new_ent = !found_reg;
                status_next = found_reg ? cist_pkg::ST_EXIST : cist_pkg::ST_NEW;
                state_next  = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.tab_wr = 1'b1;
                if (watch_enable && id_reg == watch_id && sts.differs)
                begin
                    cmd.log_wr = 1'b1;
                    lpos_next  = lpos_reg + 1'b1;
                    if (lfill_reg != cist_pkg::LFILL_W'(cist_pkg::LOG_SIZE))
                        lfill_next = lfill_reg + 1'b1;
                end
                state_next = S_RESULT;
            end
            S_READ:
            begin
                cmd.tab_rd = 1'b1;
                cmd.log_rd = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
                if (!busy_out_reg || !out_stall)
                begin
                    cmd.res_load  = 1'b1;
                    busy_out_next = 1'b1;
                    state_next    = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            addr_reg     <= '0;
            found_reg    <= 1'b0;
            status_reg   <= cist_pkg::ST_BAD;
            busy_out_reg <= 1'b0;
            total_reg    <= '0;
            fill_reg     <= '0;
            lpos_reg     <= '0;
            lfill_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            found_reg    <= found_next;
            status_reg   <= status_next;
            busy_out_reg <= busy_out_next;
            total_reg    <= total_next;
            fill_reg     <= fill_next;
            lpos_reg     <= lpos_next;
            lfill_reg    <= lfill_next;
        end
    end

    assign frame_total = total_reg;
    assign table_fill  = fill_reg;
    assign log_pos     = lpos_reg;
    assign log_fill    = lfill_reg;

endmodule

@@ rtl/can_id_statistics_table.sv @@
// Top level of the CAN identifier statistics table.
// Holds the configuration registers; instantiates cist_ctrl and cist_datapath.
//
// Usage:
//  - Input channel in_valid/in_stall carries one in_item_t per transfer:
//    a frame, a clear, a table read or a log read.
//  - Output channel out_valid/out_stall returns exactly one out_item_t per
//    input transfer, in order, from an output register.
//  - Configuration: cfg_we with cfg_index 0 (watch_enable) or 1 (watch id)
//    writes cfg_data; other indexes are ignored. Write only while idle.
//  - Search: a frame walks the table one entry at a time, through a read state
//    (S_SEARCH) and a compare state (S_CHECK) per entry, so a new or dropped
//    frame walks every filled entry; reads, clears, remote frames and bad
//    commands skip the search. The table search loop sets the rate.
//  - One item is worked on at a time; the next may enter while the previous
//    result waits in the output register.
//  - If the receiver stalls, the finished result holds and the block waits
//    before loading the next one; the input stays stalled meanwhile.
//  - Reset empties the table and the log and clears the frame total and
//    configuration; no memory clearing pass is needed.
module can_id_statistics_table
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cist_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cist_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [28:0]          cfg_data
);

    logic        watch_enable_reg;
    logic [28:0] watch_id_reg;
    cist_pkg::cmd_t cmd;
    cist_pkg::sts_t sts;
    logic [31:0] frame_total;
    logic [cist_pkg::TFILL_W-1:0] table_fill;
    logic [cist_pkg::LIDX_W-1:0]  log_pos;
    logic [cist_pkg::LFILL_W-1:0] log_fill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_enable_reg <= 1'b0;
            watch_id_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cist_pkg::CFG_WATCH_ENABLE: watch_enable_reg <= cfg_data[0];
                cist_pkg::CFG_WATCH_ID:     watch_id_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    cist_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .watch_enable (watch_enable_reg),
        .watch_id     (watch_id_reg),
        .cmd          (cmd),
        .sts          (sts),
        .frame_total  (frame_total),
        .table_fill   (table_fill),
        .log_pos      (log_pos),
        .log_fill     (log_fill)
    );

    cist_datapath u_dp
    (
        .clk          (clk),
        .cmd          (cmd),
        .sts          (sts),
        .in_item      (in_data),
        .watch_id     (watch_id_reg),
        .frame_total  (frame_total),
        .table_fill   (table_fill),
        .log_pos      (log_pos),
        .log_fill     (log_fill),
        .res          (out_data)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        table_fill <= cist_pkg::TFILL_W'(cist_pkg::TABLE_DEPTH))
        else $error("table fill beyond depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result lost under stall");
    a_log_fill: assert property (@(posedge clk) disable iff (!rst_n)
        log_fill <= cist_pkg::LFILL_W'(cist_pkg::LOG_SIZE))
        else $error("log fill beyond depth");
`endif

endmodule

@@ verif/can_id_statistics_table_tb.sv @@
// Testbench for can_id_statistics_table: directed and random frames, clears and reads,
// checked against an in-bench model of the identifier table and change log.
// Depends on cist_pkg and the can_id_statistics_table RTL.
`timescale 1ns / 1ps

module can_id_statistics_table_tb;

    localparam int CYCLE_LIMIT = 2_000_000;

    // command codes with no function in the block
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    cist_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    cist_pkg::out_item_t out_data;
    logic      cfg_we;
    logic      cfg_index;
    logic [28:0] cfg_data;

    can_id_statistics_table uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    logic [28:0] tab_id    [cist_pkg::TABLE_DEPTH];
    logic [3:0]  tab_len   [cist_pkg::TABLE_DEPTH];
    logic [31:0] tab_cnt   [cist_pkg::TABLE_DEPTH];
    logic [31:0] tab_first [cist_pkg::TABLE_DEPTH];
    logic [31:0] tab_last  [cist_pkg::TABLE_DEPTH];
    logic [63:0] tab_data  [cist_pkg::TABLE_DEPTH];
    logic [7:0]  tab_chg   [cist_pkg::TABLE_DEPTH];
    logic [63:0] tab_lo    [cist_pkg::TABLE_DEPTH];
    logic [63:0] tab_hi    [cist_pkg::TABLE_DEPTH];
    int          tab_fill;
    logic [31:0] frame_total;
    logic [31:0] log_time  [cist_pkg::LOG_SIZE];
    logic [3:0]  log_len   [cist_pkg::LOG_SIZE];
    logic [63:0] log_data  [cist_pkg::LOG_SIZE];
    int          log_wr;
    int          log_fill;
    logic        watch_en;
    logic [28:0] watch_id;

    cist_pkg::out_item_t pending_results[$];
    cist_pkg::out_item_t want;
    int          errors;
    int          cycles;
    int          stall_left;
    int          hold_cycles;
    bit          idle_on;

    logic [28:0] id_pool[12];
    logic [63:0] pool_data[12];

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("can_id_statistics_table test failed");
            $finish;
        end
    end

    function automatic cist_pkg::out_item_t entry_result(cist_pkg::out_item_t r, int e);
        r.entry_id     = tab_id[e];
        r.entry_length = tab_len[e];
        r.entry_count  = tab_cnt[e];
        r.first_time   = tab_first[e];
        r.last_time    = tab_last[e];
        r.last_payload = tab_data[e];
        r.chg_mask     = tab_chg[e];
        r.low_bytes    = tab_lo[e];
        r.high_bytes   = tab_hi[e];
        return r;
    endfunction

    function automatic cist_pkg::out_item_t predict_stats(cist_pkg::in_item_t it);
        cist_pkg::out_item_t r;
        int          e;
        int          p;
        bit          found;
        bit          differs;
        bit          log_read;
        logic [3:0]  len;
        logic [63:0] m;
        logic [7:0]  b;
        r = '0;
        log_read = 0;
        case (it.cmd)
            cist_pkg::CMD_FRAME: begin
                if (it.remote_frame) begin
                    r.status   = cist_pkg::ST_REMOTE;
                    r.entry_id = it.frame_id;
                end else begin
                    if (frame_total != 32'hFFFF_FFFF) frame_total++;
                    found = 0;
                    e = 0;
                    for (int k = 0; k < tab_fill; k++)
                        if (!found && tab_id[k] == it.frame_id) begin
                            found = 1;
                            e = k;
                        end
                    if (!found && tab_fill >= cist_pkg::TABLE_DEPTH) begin
                        r.status   = cist_pkg::ST_FULL;
                        r.entry_id = it.frame_id;
                    end else begin
                        if (!found) begin
                            e = tab_fill;
                            tab_fill++;
                            tab_id[e]    = it.frame_id;
                            tab_len[e]   = 4'd0;
                            tab_cnt[e]   = 32'd0;
                            tab_first[e] = it.time_ms;
                            tab_last[e]  = 32'd0;
                            tab_data[e]  = 64'd0;
                            tab_chg[e]   = 8'd0;
                            tab_lo[e]    = '1;
                            tab_hi[e]    = 64'd0;
                        end
                        len = (it.length_code > 4'd8) ? 4'd8 : it.length_code;
                        m = '0;
                        for (int k = 0; k < int'(len); k++) begin
                            m[8*k +: 8] = 8'hFF;
                            b = it.payload[8*k +: 8];
                            if (tab_cnt[e] != 0 && b != tab_data[e][8*k +: 8])
                                tab_chg[e][k] = 1'b1;
                            if (b < tab_lo[e][8*k +: 8]) tab_lo[e][8*k +: 8] = b;
                            if (b > tab_hi[e][8*k +: 8]) tab_hi[e][8*k +: 8] = b;
                        end
                        differs = tab_cnt[e] == 0 || len != tab_len[e] ||
                                  ((tab_data[e] ^ it.payload) & m) != 0;
                        tab_len[e]  = len;
                        tab_data[e] = (tab_data[e] & ~m) | (it.payload & m);
                        if (tab_cnt[e] != 32'hFFFF_FFFF) tab_cnt[e]++;
                        tab_last[e] = it.time_ms;
                        if (watch_en && it.frame_id == watch_id && differs) begin
                            log_time[log_wr] = it.time_ms;
                            log_len[log_wr]  = len;
                            log_data[log_wr] = it.payload & m;
                            log_wr = (log_wr + 1) % cist_pkg::LOG_SIZE;
                            if (log_fill < cist_pkg::LOG_SIZE) log_fill++;
                        end
                        r.status = found ? cist_pkg::ST_EXIST : cist_pkg::ST_NEW;
                        r = entry_result(r, e);
                    end
                end
            end
            cist_pkg::CMD_CLEAR_ALL: begin
                tab_fill = 0;
                frame_total = 32'd0;
                log_wr = 0;
                log_fill = 0;
                r.status = cist_pkg::ST_CLEARED;
            end
            cist_pkg::CMD_CLEAR_LOG: begin
                log_wr = 0;
                log_fill = 0;
                r.status = cist_pkg::ST_CLEARED;
            end
            cist_pkg::CMD_READ_TAB: begin
                if (int'(it.read_index) < tab_fill) begin
                    r.status = cist_pkg::ST_TREAD;
                    r = entry_result(r, int'(it.read_index));
                end else
                    r.status = cist_pkg::ST_BAD;
            end
            cist_pkg::CMD_READ_LOG: begin
                log_read = 1;
                if (int'(it.read_index) < log_fill) begin
                    p = (log_wr + cist_pkg::LOG_SIZE - log_fill + int'(it.read_index))
                        % cist_pkg::LOG_SIZE;
                    r.status       = cist_pkg::ST_LREAD;
                    r.entry_id     = watch_id;
                    r.entry_length = log_len[p];
                    r.last_time    = log_time[p];
                    r.last_payload = log_data[p];
                end else
                    r.status = cist_pkg::ST_BAD;
            end
            default: r.status = cist_pkg::ST_BAD;
        endcase
        r.total_frames = frame_total;
        r.fill_count   = 9'(log_read ? log_fill : tab_fill);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // result checker and receiver stall counts
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, got status %0d",
                         $time, out_data.status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(out_data.status));
                check_field("entry_id", 64'(want.entry_id), 64'(out_data.entry_id));
                check_field("entry_length", 64'(want.entry_length),
                            64'(out_data.entry_length));
                check_field("entry_count", 64'(want.entry_count),
                            64'(out_data.entry_count));
                check_field("first_time", 64'(want.first_time), 64'(out_data.first_time));
                check_field("last_time", 64'(want.last_time), 64'(out_data.last_time));
                check_field("last_payload", want.last_payload, out_data.last_payload);
                check_field("chg_mask", 64'(want.chg_mask), 64'(out_data.chg_mask));
                check_field("low_bytes", want.low_bytes, out_data.low_bytes);
                check_field("high_bytes", want.high_bytes, out_data.high_bytes);
                check_field("total_frames", 64'(want.total_frames),
                            64'(out_data.total_frames));
                check_field("fill_count", 64'(want.fill_count), 64'(out_data.fill_count));
            end
            stall_left = idle_on ? int'($urandom_range(0, 5)) : 0;
        end
    end

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall = 1'b1;
            hold_cycles--;
        end else if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else
            out_stall = 1'b0;
    end

    // one input transfer; called and returns at a falling edge
    task automatic send_item(cist_pkg::in_item_t it);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = it;
        in_valid = 1'b1;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        pending_results.push_back(predict_stats(it));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [28:0] value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_data = 29'($urandom);
        if (idx == cist_pkg::CFG_WATCH_ENABLE) watch_en = value[0];
        else watch_id = value;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic cist_pkg::in_item_t mk_frame(logic [28:0] id, logic [3:0] len,
                                                    logic [63:0] data, logic [31:0] t,
                                                    logic rmt);
        cist_pkg::in_item_t it;
        it.cmd          = cist_pkg::CMD_FRAME;
        it.frame_id     = id;
        it.length_code  = len;
        it.payload      = data;
        it.remote_frame = rmt;
        it.time_ms      = t;
        it.read_index   = 8'($urandom);
        return it;
    endfunction

    function automatic cist_pkg::in_item_t mk_cmd(logic [2:0] c, logic [7:0] idx);
        cist_pkg::in_item_t it;
        it = mk_frame(29'($urandom), 4'($urandom), rand64(), $urandom, 1'($urandom));
        it.cmd = c;
        it.read_index = idx;
        return it;
    endfunction

    task automatic test_directed();
        write_reg(cist_pkg::CFG_WATCH_ENABLE, 29'd1);
        write_reg(cist_pkg::CFG_WATCH_ID, 29'h1FFF_FFFF);
        send_item(mk_cmd(cist_pkg::CMD_CLEAR_ALL, 8'd0));
        send_item(mk_frame(29'h1FFF_FFFF, 4'd8, '1, 32'h0, 1'b0));
        send_item(mk_frame(29'h1FFF_FFFF, 4'd8, '1, 32'h10, 1'b0));   // unchanged: no log
        send_item(mk_frame(29'h1FFF_FFFF, 4'd3, '0, 32'hFFFF_FFFF, 1'b0));
        send_item(mk_frame(29'h1FFF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF, 32'h5, 1'b0));
        send_item(mk_frame(29'h0, 4'd8, rand64(), 32'h7, 1'b1));      // remote
        send_item(mk_frame(29'h0, 4'd0, rand64(), 32'h8, 1'b0));
        send_item(mk_frame(29'h7FF, 4'd8, rand64(), 32'h9, 1'b0));
        send_item(mk_frame(29'h7FF, 4'd2, rand64(), 32'hA, 1'b0));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'd0));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'd2));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'd3));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'hFF));
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'd0));
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'd2));
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'd3));
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'hFF));
        send_item(mk_cmd(CMD_SPARE_A, 8'd0));
        send_item(mk_cmd(CMD_SPARE_B, 8'd0));
        send_item(mk_cmd(CMD_SPARE_C, 8'hFF));
        send_item(mk_cmd(cist_pkg::CMD_CLEAR_LOG, 8'd0));
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'd0));
        send_item(mk_cmd(cist_pkg::CMD_CLEAR_ALL, 8'd0));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'd0));
    endtask

    // more distinct identifiers than entries, so the last ones are dropped
    task automatic test_table_full();
        write_reg(cist_pkg::CFG_WATCH_ENABLE, 29'd0);
        send_item(mk_cmd(cist_pkg::CMD_CLEAR_ALL, 8'd0));
        idle_on = 0;
        for (int k = 0; k < cist_pkg::TABLE_DEPTH + 4; k++)
            send_item(mk_frame({21'($urandom), 8'(k)}, 4'($urandom), rand64(),
                               $urandom, 1'b0));
        idle_on = 1;
        send_item(mk_frame(tab_id[cist_pkg::TABLE_DEPTH-1], 4'd8, rand64(), $urandom, 1'b0));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'(cist_pkg::TABLE_DEPTH - 1)));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'(cist_pkg::TABLE_DEPTH)));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB,
                         8'($urandom_range(0, cist_pkg::TABLE_DEPTH - 1))));
    endtask

    // many frames of one identifier, most of them changed, with log reads between them
    task automatic test_log_wrap();
        logic [28:0] id;
        logic [63:0] data;
        logic [3:0]  len;
        id = 29'($urandom);
        data = rand64();
        len = 4'd8;
        write_reg(cist_pkg::CFG_WATCH_ID, id);
        write_reg(cist_pkg::CFG_WATCH_ENABLE, 29'd1);
        send_item(mk_cmd(cist_pkg::CMD_CLEAR_ALL, 8'd0));
        for (int k = 0; k < 270; k++) begin
            if ($urandom_range(0, 9) > 1) begin
                data = ($urandom_range(0, 1)) ? rand64() :
                       data ^ (64'h1 << $urandom_range(0, 63));
                len = ($urandom_range(0, 3) == 0) ? 4'($urandom) : len;
            end
            send_item(mk_frame(id, len, data, $urandom, 1'b0));
            if (k % 60 == 59)
                send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'($urandom)));
        end
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'd0));
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'hFF));
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'd0));
    endtask

    // receiver holds off while items keep coming, then the sender waits for all results
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 8; k++)
            send_item(mk_frame(id_pool[$urandom_range(0, 11)], 4'($urandom), rand64(),
                               $urandom, 1'b0));
        wait_drained();
        send_item(mk_cmd(cist_pkg::CMD_READ_TAB, 8'd0));
    endtask

    task automatic test_random_traffic();
        int sel;
        int slot;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(cist_pkg::CFG_WATCH_ENABLE, 29'(phase != 1));
            write_reg(cist_pkg::CFG_WATCH_ID, id_pool[$urandom_range(0, 11)]);
            if (phase == 0) send_item(mk_cmd(cist_pkg::CMD_CLEAR_ALL, 8'd0));
            idle_on = (phase != 2);
            for (int k = 0; k < 50; k++) begin
                sel = int'($urandom_range(0, 99));
                slot = int'($urandom_range(0, 11));
                if (sel < 60) begin
                    if ($urandom_range(0, 2) == 0) pool_data[slot] = rand64();
                    else if ($urandom_range(0, 1) == 0)
                        pool_data[slot][8*$urandom_range(0, 7) +: 8] = 8'($urandom);
                    send_item(mk_frame(id_pool[slot],
                                       ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd8,
                                       pool_data[slot], $urandom, 1'b0));
                end else if (sel < 67)
                    send_item(mk_frame(id_pool[slot], 4'($urandom), rand64(), $urandom,
                                       1'b1));
                else if (sel < 72)
                    send_item(mk_frame(29'($urandom), 4'($urandom), rand64(), $urandom,
                                       1'b0));
                else if (sel < 82)
                    send_item(mk_cmd(cist_pkg::CMD_READ_TAB, ($urandom_range(0, 3) == 0) ?
                                     8'($urandom) : 8'($urandom_range(0, tab_fill))));
                else if (sel < 92)
                    send_item(mk_cmd(cist_pkg::CMD_READ_LOG, ($urandom_range(0, 3) == 0) ?
                                     8'($urandom) : 8'($urandom_range(0, log_fill))));
                else if (sel < 94)
                    send_item(mk_cmd(cist_pkg::CMD_CLEAR_LOG, 8'($urandom)));
                else if (sel < 95)
                    send_item(mk_cmd(cist_pkg::CMD_CLEAR_ALL, 8'($urandom)));
                else
                    send_item(mk_cmd(3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)),
                                     8'($urandom)));
            end
        end
        idle_on = 1;
        write_reg(cist_pkg::CFG_WATCH_ENABLE, 29'd0);
        write_reg(cist_pkg::CFG_WATCH_ID, 29'h0);
        send_item(mk_frame(29'h0, 4'd8, rand64(), $urandom, 1'b0));
        send_item(mk_cmd(cist_pkg::CMD_READ_LOG, 8'd0));
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        stall_left = 0;
        hold_cycles = 0;
        idle_on = 1;
        tab_fill = 0;
        frame_total = 32'd0;
        log_wr = 0;
        log_fill = 0;
        watch_en = 1'b0;
        watch_id = 29'd0;
        id_pool[0] = 29'h0;
        id_pool[1] = 29'h1FFF_FFFF;
        id_pool[2] = 29'h7FF;
        for (int k = 3; k < 12; k++) id_pool[k] = 29'($urandom);
        for (int k = 0; k < 12; k++) pool_data[k] = rand64();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_log_wrap();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("can_id_statistics_table test passed");
        else
            $display("can_id_statistics_table test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cist_pkg.sv
rtl/cist_datapath.sv
rtl/cist_ctrl.sv
rtl/can_id_statistics_table.sv
verif/can_id_statistics_table_tb.sv
